// File: rtl/prq_pkg.sv
// Package: shared types, status codes and default sizes for the packet ring queue.
`timescale 1ns / 1ps

package prq_pkg;

  localparam int QUEUE_SLOTS_DEF  = 8;
  localparam int PACKET_BYTES_DEF = 256;
  localparam int WAITING_MAX      = 7;

  typedef enum logic [2:0] {
    PS_NONE     = 3'd0,
    PS_STORED   = 3'd1,
    PS_QUEUED   = 3'd2,
    PS_FULL     = 3'd3,
    PS_TOO_LONG = 3'd4
  } push_status_t;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } tx_state_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] data_byte;
    logic       last_byte;
  } prq_item_t;

  typedef struct packed {
    push_status_t push_status;
    logic         tx_valid;
    logic [7:0]   tx_byte;
    logic         tx_end_of_packet;
    logic [2:0]   packets_waiting;
  } prq_result_t;

endpackage

// File: rtl/prq_buf.sv
// Packet byte store and per-slot length table, both with registered reads.
`timescale 1ns / 1ps

module prq_buf import prq_pkg::*; #(
  parameter int QUEUE_SLOTS  = QUEUE_SLOTS_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF,
  localparam int SW = $clog2(QUEUE_SLOTS),
  localparam int OW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1,
  localparam int CW = $clog2(PACKET_BYTES + 1),
  localparam int AW = $clog2(QUEUE_SLOTS * PACKET_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_base,
  input  logic [CW-1:0] wr_offset,
  input  logic [7:0]    wr_data,
  input  logic          len_wr_en,
  input  logic [SW-1:0] len_wr_slot,
  input  logic [CW-1:0] len_wr_value,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_base,
  input  logic [OW-1:0] rd_offset,
  input  logic [SW-1:0] rd_slot,
  output logic [7:0]    rd_data,
  output logic [CW-1:0] rd_len
);

  localparam int DEPTH = QUEUE_SLOTS * PACKET_BYTES;

  logic [7:0]    store_mem [DEPTH];
  logic [CW-1:0] len_mem   [QUEUE_SLOTS];

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_addr = wr_base + AW'(wr_offset);
  assign rd_addr = rd_base + AW'(rd_offset);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_wr_en) begin
      len_mem[len_wr_slot] <= len_wr_value;
    end
    if (rd_en) begin
      rd_len <= len_mem[rd_slot];
    end
  end

endmodule

// File: rtl/packet_ring_queue_transmitter.sv
// Top level: packet ring transmit queue with byte pushes and line-ready ticks.
//
//   channel   ports                 handshake
//   --------  --------------------  -------------------------------------
//   item in   item                  taken on the edge with start & !busy
//   result    result                valid for one cycle while done is high
//
// A push writes the store at the accepting edge; the result follows in the next cycle.
// A tick on an empty ring also answers in the next cycle. A tick on a non-empty ring
// reads the store and length table (registered reads), so busy is high for
// one cycle in ST_READ and the result is registered from the ST_READ state.
// Reset clears pointers, counts and flags; store contents are undefined until written.
// The receiver cannot stall; done is a one-cycle strobe.
`timescale 1ns / 1ps

module packet_ring_queue_transmitter import prq_pkg::*; #(
  parameter int QUEUE_SLOTS  = QUEUE_SLOTS_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  prq_item_t   item,
  output logic        done,
  output prq_result_t result
);

  localparam int SW = $clog2(QUEUE_SLOTS);
  localparam int OW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam int AW = $clog2(QUEUE_SLOTS * PACKET_BYTES);
  localparam int NW = $clog2(QUEUE_SLOTS);

  tx_state_t   state, state_next;
  logic [SW-1:0] write_slot, write_slot_next;
  logic [SW-1:0] read_slot, read_slot_next;
  logic [AW-1:0] write_base, write_base_next;
  logic [AW-1:0] read_base, read_base_next;
  logic [CW-1:0] write_count, write_count_next;
  logic [OW-1:0] read_offset, read_offset_next;
  logic          overlength_flag, overlength_flag_next;
  logic [NW-1:0] count, count_next;
  logic          done_next;
  prq_result_t   result_next;

  logic          accept, is_push, is_tick;
  logic          room, full, empty, ovl;
  logic          wr_en, commit, rd_en;
  logic [7:0]    rd_data;
  logic [CW-1:0] rd_len;
  logic [CW-1:0] off_inc;
  logic          eop;
  push_status_t  status;

  assign accept  = start && !busy;
  assign is_push = accept && (item.action == ACT_PUSH);
  assign is_tick = accept && (item.action == ACT_TICK);
  assign room    = write_count < CW'(PACKET_BYTES);
  assign full    = count == NW'(QUEUE_SLOTS - 1);
  assign empty   = count == '0;
  assign ovl     = overlength_flag || !room;
  assign wr_en   = is_push && room;
  assign commit  = is_push && item.last_byte && !ovl && !full;
  assign off_inc = CW'(read_offset) + CW'(1);
  assign eop     = off_inc >= rd_len;

  prq_buf #(
    .QUEUE_SLOTS  (QUEUE_SLOTS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_buf (
    .clk          (clk),
    .wr_en        (wr_en),
    .wr_base      (write_base),
    .wr_offset    (write_count),
    .wr_data      (item.data_byte),
    .len_wr_en    (commit),
    .len_wr_slot  (write_slot),
    .len_wr_value (write_count + CW'(1)),
    .rd_en        (rd_en),
    .rd_base      (read_base),
    .rd_offset    (read_offset),
    .rd_slot      (read_slot),
    .rd_data      (rd_data),
    .rd_len       (rd_len)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (is_tick && !empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b0;
    rd_en = 1'b0;
    case (state)
      ST_IDLE: rd_en = is_tick && !empty;
      ST_READ: busy  = 1'b1;
      default: busy  = 1'b0;
    endcase
  end

  always_comb begin
    write_slot_next      = write_slot;
    read_slot_next       = read_slot;
    write_base_next      = write_base;
    read_base_next       = read_base;
    write_count_next     = write_count;
    read_offset_next     = read_offset;
    overlength_flag_next = overlength_flag;
    count_next           = count;
    done_next            = 1'b0;
    status               = room ? PS_STORED : PS_TOO_LONG;
    result_next          = result;

    if (is_push) begin
      write_count_next     = room ? write_count + CW'(1) : write_count;
      overlength_flag_next = ovl;
      if (item.last_byte) begin
        if (ovl) begin
          status = PS_TOO_LONG;
        end else if (full) begin
          status = PS_FULL;
        end else begin
          status = PS_QUEUED;
        end
        write_count_next     = '0;
        overlength_flag_next = 1'b0;
      end
      if (commit) begin
        count_next = count + NW'(1);
        if (write_slot == SW'(QUEUE_SLOTS - 1)) begin
          write_slot_next = '0;
          write_base_next = '0;
        end else begin
          write_slot_next = write_slot + SW'(1);
          write_base_next = write_base + AW'(PACKET_BYTES);
        end
      end
    end

    if (state == ST_READ && eop) begin
      read_offset_next = '0;
      count_next       = count - NW'(1);
      if (read_slot == SW'(QUEUE_SLOTS - 1)) begin
        read_slot_next = '0;
        read_base_next = '0;
      end else begin
        read_slot_next = read_slot + SW'(1);
        read_base_next = read_base + AW'(PACKET_BYTES);
      end
    end else if (state == ST_READ) begin
      read_offset_next = off_inc[OW-1:0];
    end

    if (is_push || (is_tick && empty) || state == ST_READ) begin
      done_next                    = 1'b1;
      result_next.push_status      = is_push ? status : PS_NONE;
      result_next.tx_valid         = state == ST_READ;
      result_next.tx_byte          = (state == ST_READ) ? rd_data : 8'd0;
      result_next.tx_end_of_packet = (state == ST_READ) && eop;
      result_next.packets_waiting  = (int'(count_next) > WAITING_MAX) ?
                                     3'(WAITING_MAX) : 3'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      write_slot      <= '0;
      read_slot       <= '0;
      write_base      <= '0;
      read_base       <= '0;
      write_count     <= '0;
      read_offset     <= '0;
      overlength_flag <= 1'b0;
      count           <= '0;
      done            <= 1'b0;
    end else begin
      state           <= state_next;
      write_slot      <= write_slot_next;
      read_slot       <= read_slot_next;
      write_base      <= write_base_next;
      read_base       <= read_base_next;
      write_count     <= write_count_next;
      read_offset     <= read_offset_next;
      overlength_flag <= overlength_flag_next;
      count           <= count_next;
      done            <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_IDLE && done)
    else $error("store read did not finish in one cycle");

  a_push_no_tx: assert property (@(posedge clk) disable iff (rst)
    done && result.push_status != PS_NONE |-> !result.tx_valid)
    else $error("push item produced a line byte");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= QUEUE_SLOTS - 1)
    else $error("ring holds more packets than slots minus one");

  a_empty_ring: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (read_slot == write_slot))
    else $error("packet count disagrees with slot pointers");

endmodule
